/* hdl/scct_pkg.sv */
`default_nettype none

package scct_pkg;

   // orientation codes of one cross product
   localparam logic [1:0] ORIENT_COLL = 2'd0;
   localparam logic [1:0] ORIENT_POS  = 2'd1;
   localparam logic [1:0] ORIENT_NEG  = 2'd2;

   // per-stage load enables shared by every lane
   typedef struct packed {
      logic s1_en;
      logic s2_en;
      logic s3_en;
   } pipe_ctl_type;

endpackage

`default_nettype wire

/* hdl/scct_if.sv */
`default_nettype none

interface scct_req_if #(parameter int COORD_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_BITS-1:0]  ray_start_x;
   logic signed [COORD_BITS-1:0]  ray_start_y;
   logic signed [COORD_BITS-1:0]  ray_end_x;
   logic signed [COORD_BITS-1:0]  ray_end_y;
   logic signed [COORD_BITS-1:0]  corner_a_x;
   logic signed [COORD_BITS-1:0]  corner_a_y;
   logic signed [COORD_BITS-1:0]  corner_b_x;
   logic signed [COORD_BITS-1:0]  corner_b_y;
   logic signed [COORD_BITS-1:0]  corner_c_x;
   logic signed [COORD_BITS-1:0]  corner_c_y;
   logic signed [COORD_BITS-1:0]  corner_d_x;
   logic signed [COORD_BITS-1:0]  corner_d_y;

   modport source (
      output valid, ray_start_x, ray_start_y, ray_end_x, ray_end_y,
             corner_a_x, corner_a_y, corner_b_x, corner_b_y,
             corner_c_x, corner_c_y, corner_d_x, corner_d_y,
      input  ready
   );
   modport sink (
      input  valid, ray_start_x, ray_start_y, ray_end_x, ray_end_y,
             corner_a_x, corner_a_y, corner_b_x, corner_b_y,
             corner_c_x, corner_c_y, corner_d_x, corner_d_y,
      output ready
   );
endinterface

interface scct_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink   (input valid, hit, output ready);
endinterface

`default_nettype wire

/* hdl/scct_orient_lane.sv */
`default_nettype none

// One orientation test orient(p, q, r) plus "r inside box of p-q".
// Three register stages: differences, products, sign/zero of the cross value.
module scct_orient_lane
   import scct_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  wire logic                         clock,
   input  wire pipe_ctl_type                 ctl,
   input  wire logic signed [COORD_BITS-1:0] p_x,
   input  wire logic signed [COORD_BITS-1:0] p_y,
   input  wire logic signed [COORD_BITS-1:0] q_x,
   input  wire logic signed [COORD_BITS-1:0] q_y,
   input  wire logic signed [COORD_BITS-1:0] r_x,
   input  wire logic signed [COORD_BITS-1:0] r_y,
   output logic [1:0]                        code,
   output logic                              inbox
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int CW = PW + 1;

   logic signed [DW-1:0] d1_in, d2_in, d3_in, d4_in;
   logic signed [DW-1:0] d1_ff, d2_ff, d3_ff, d4_ff;
   logic signed [PW-1:0] u_in, v_in, u_ff, v_ff;
   logic signed [CW-1:0] cross_in;
   logic [1:0]           code_in, code_ff;
   logic                 box_in, box1_ff, box2_ff, box3_ff;

   // stage 1: coordinate differences and box check
   assign d1_in = DW'(q_y) - DW'(p_y);
   assign d2_in = DW'(r_x) - DW'(q_x);
   assign d3_in = DW'(q_x) - DW'(p_x);
   assign d4_in = DW'(r_y) - DW'(q_y);

   assign box_in = ((r_x <= p_x) || (r_x <= q_x)) && ((r_x >= p_x) || (r_x >= q_x)) &&
                   ((r_y <= p_y) || (r_y <= q_y)) && ((r_y >= p_y) || (r_y >= q_y));

   // stage 2: exact products
   assign u_in = d1_ff * d2_ff;
   assign v_in = d3_ff * d4_ff;

   // stage 3: cross value sign
   assign cross_in = CW'(u_ff) - CW'(v_ff);

   always_comb begin
      if (cross_in == '0) begin
         code_in = ORIENT_COLL;
      end else if (cross_in[CW-1]) begin
         code_in = ORIENT_NEG;
      end else begin
         code_in = ORIENT_POS;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         d1_ff   <= d1_in;
         d2_ff   <= d2_in;
         d3_ff   <= d3_in;
         d4_ff   <= d4_in;
         box1_ff <= box_in;
      end
      if (ctl.s2_en) begin
         u_ff    <= u_in;
         v_ff    <= v_in;
         box2_ff <= box1_ff;
      end
      if (ctl.s3_en) begin
         code_ff <= code_in;
         box3_ff <= box2_ff;
      end
   end

   assign code  = code_ff;
   assign inbox = box3_ff;

endmodule

`default_nettype wire

/* hdl/segment_cell_crossing_test.sv */
// Ray versus map cell crossing test. Each request beat carries a ray segment and
// the four corners a..d of a cell; one response beat returns hit = 1 when the ray
// touches or crosses any of the sides a-b, b-c, c-d or a-d (end points, corners
// and collinear overlap count). Cross products are exact, so the answer never
// depends on rounding. The pipeline takes one beat per clock unless the response
// stalls, and answers through four register stages (differences, multipliers,
// cross-value sign, side combine into the output register); the twelve
// multiplier pairs of the second stage set the one-per-clock rate.
// A stalled response only holds back stages that are full; bubbles still fill.
`default_nettype none

module segment_cell_crossing_test
   import scct_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   scct_req_if.sink    req_if,
   scct_rsp_if.source  rsp_if
);

   localparam int NUM_LANES = 12;

   // side endpoints as corner indices: a-b, b-c, c-d, a-d
   localparam int SIDE_P [4] = '{0, 1, 2, 0};
   localparam int SIDE_Q [4] = '{1, 2, 3, 3};

   logic signed [COORD_BITS-1:0] cx [4];
   logic signed [COORD_BITS-1:0] cy [4];

   logic [1:0]   code  [NUM_LANES];
   logic         inbox [NUM_LANES];
   logic [3:0]   side_hit;

   pipe_ctl_type ctl;
   logic         en1, en2, en3, en4;
   logic         v1_ff, v2_ff, v3_ff, v4_ff;
   logic         hit_in, hit_ff;

   // ---------------------------------------------------------------
   // Flow control: a stage loads when empty or when the next one loads
   // ---------------------------------------------------------------
   assign en4 = !v4_ff || rsp_if.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign ctl.s1_en = en1;
   assign ctl.s2_en = en2;
   assign ctl.s3_en = en3;

   assign req_if.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_if.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // ---------------------------------------------------------------
   // Orientation lanes
   //   lanes 0..3 : orient(start, end, corner k), corner k in ray box
   //   lanes 4+2j : orient(side j, start), start in side box
   //   lanes 5+2j : orient(side j, end),   end in side box
   // ---------------------------------------------------------------
   assign cx[0] = req_if.corner_a_x;  assign cy[0] = req_if.corner_a_y;
   assign cx[1] = req_if.corner_b_x;  assign cy[1] = req_if.corner_b_y;
   assign cx[2] = req_if.corner_c_x;  assign cy[2] = req_if.corner_c_y;
   assign cx[3] = req_if.corner_d_x;  assign cy[3] = req_if.corner_d_y;

   for (genvar k = 0; k < 4; k++) begin : g_ray
      scct_orient_lane #(.COORD_BITS(COORD_BITS)) u_lane (
         .clock (clock),
         .ctl   (ctl),
         .p_x   (req_if.ray_start_x),
         .p_y   (req_if.ray_start_y),
         .q_x   (req_if.ray_end_x),
         .q_y   (req_if.ray_end_y),
         .r_x   (cx[k]),
         .r_y   (cy[k]),
         .code  (code[k]),
         .inbox (inbox[k])
      );
   end

   for (genvar j = 0; j < 4; j++) begin : g_side
      scct_orient_lane #(.COORD_BITS(COORD_BITS)) u_lane_s (
         .clock (clock),
         .ctl   (ctl),
         .p_x   (cx[SIDE_P[j]]),
         .p_y   (cy[SIDE_P[j]]),
         .q_x   (cx[SIDE_Q[j]]),
         .q_y   (cy[SIDE_Q[j]]),
         .r_x   (req_if.ray_start_x),
         .r_y   (req_if.ray_start_y),
         .code  (code[4 + 2*j]),
         .inbox (inbox[4 + 2*j])
      );
      scct_orient_lane #(.COORD_BITS(COORD_BITS)) u_lane_e (
         .clock (clock),
         .ctl   (ctl),
         .p_x   (cx[SIDE_P[j]]),
         .p_y   (cy[SIDE_P[j]]),
         .q_x   (cx[SIDE_Q[j]]),
         .q_y   (cy[SIDE_Q[j]]),
         .r_x   (req_if.ray_end_x),
         .r_y   (req_if.ray_end_y),
         .code  (code[5 + 2*j]),
         .inbox (inbox[5 + 2*j])
      );

      // proper crossing, or a collinear end point lying on the other segment
      assign side_hit[j] =
         ((code[SIDE_P[j]] != code[SIDE_Q[j]]) && (code[4 + 2*j] != code[5 + 2*j])) ||
         ((code[SIDE_P[j]] == ORIENT_COLL) && inbox[SIDE_P[j]]) ||
         ((code[SIDE_Q[j]] == ORIENT_COLL) && inbox[SIDE_Q[j]]) ||
         ((code[4 + 2*j]   == ORIENT_COLL) && inbox[4 + 2*j])   ||
         ((code[5 + 2*j]   == ORIENT_COLL) && inbox[5 + 2*j]);
   end

   // ---------------------------------------------------------------
   // Stage 4: combine sides into the output register
   // ---------------------------------------------------------------
   assign hit_in = |side_hit;

   always_ff @(posedge clock) begin
      if (en4) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_if.valid = v4_ff;
   assign rsp_if.hit   = hit_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> v1_ff)
      else $error("accepted beat did not enter stage 1");

   a_empty_s1_ready: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_if.ready)
      else $error("empty pipeline refused a beat");

   a_stall_holds_s3: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !rsp_if.ready && v3_ff) |=> v3_ff)
      else $error("stage 3 beat lost during output stall");

   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!v1_ff && !v2_ff && !v3_ff && !v4_ff))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

/* tb/crossing_check_pkg.sv */
package crossing_check_pkg;
   import scct_pkg::*;

   localparam int COORD_BITS = 16;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // one request beat: ray segment plus the four cell corners
   typedef struct packed {
      coord_type ray_start_x;
      coord_type ray_start_y;
      coord_type ray_end_x;
      coord_type ray_end_y;
      coord_type corner_a_x;
      coord_type corner_a_y;
      coord_type corner_b_x;
      coord_type corner_b_y;
      coord_type corner_c_x;
      coord_type corner_c_y;
      coord_type corner_d_x;
      coord_type corner_d_y;
   } cell_ray_type;

   // wide enough that no difference or product can overflow
   typedef logic signed [127:0] wide_type;

   typedef struct {
      wide_type x;
      wide_type y;
   } point_type;

   function automatic point_type make_point(coord_type x, coord_type y);
      point_type p;
      p.x = x;
      p.y = y;
      return p;
   endfunction

   // sign of the turn p -> q -> r
   function automatic logic [1:0] turn_of(point_type p, point_type q, point_type r);
      wide_type cross_val;
      cross_val = (q.y - p.y) * (r.x - q.x) - (q.x - p.x) * (r.y - q.y);
      if (cross_val == 0) return ORIENT_COLL;
      return (cross_val < 0) ? ORIENT_NEG : ORIENT_POS;
   endfunction

   // q within the bounding box of p-r, borders included
   function automatic bit in_box(point_type p, point_type q, point_type r);
      return ((q.x <= p.x) || (q.x <= r.x)) && ((q.x >= p.x) || (q.x >= r.x)) &&
             ((q.y <= p.y) || (q.y <= r.y)) && ((q.y >= p.y) || (q.y >= r.y));
   endfunction

   function automatic bit segments_meet(point_type p1, point_type q1,
                                        point_type p2, point_type q2);
      logic [1:0] o1, o2, o3, o4;
      o1 = turn_of(p1, q1, p2);
      o2 = turn_of(p1, q1, q2);
      o3 = turn_of(p2, q2, p1);
      o4 = turn_of(p2, q2, q1);
      if (o1 != o2 && o3 != o4) return 1'b1;
      if (o1 == ORIENT_COLL && in_box(p1, p2, q1)) return 1'b1;
      if (o2 == ORIENT_COLL && in_box(p1, q2, q1)) return 1'b1;
      if (o3 == ORIENT_COLL && in_box(p2, p1, q2)) return 1'b1;
      if (o4 == ORIENT_COLL && in_box(p2, q1, q2)) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit predict_hit(cell_ray_type beat);
      point_type s, e, a, b, c, d;
      s = make_point(beat.ray_start_x, beat.ray_start_y);
      e = make_point(beat.ray_end_x, beat.ray_end_y);
      a = make_point(beat.corner_a_x, beat.corner_a_y);
      b = make_point(beat.corner_b_x, beat.corner_b_y);
      c = make_point(beat.corner_c_x, beat.corner_c_y);
      d = make_point(beat.corner_d_x, beat.corner_d_y);
      return segments_meet(s, e, a, b) || segments_meet(s, e, b, c) ||
             segments_meet(s, e, c, d) || segments_meet(s, e, a, d);
   endfunction

   class hit_scoreboard;
      bit          expected_hits[$];
      int unsigned fail_count;

      function new();
         fail_count = 0;
      endfunction

      function void note_request(cell_ray_type beat);
         expected_hits = {expected_hits, predict_hit(beat)};
      endfunction

      function void check_hit(logic actual);
         bit want;
         if (expected_hits.size() == 0) begin
            $error("hit: response beat with nothing expected, actual %0b", actual);
            fail_count++;
            return;
         end
         want = expected_hits.pop_front();
         if (actual !== want) begin
            $error("hit: expected %0b, actual %0b", want, actual);
            fail_count++;
         end
      endfunction

      function int unsigned pending();
         return expected_hits.size();
      endfunction
   endclass

endpackage

/* tb/segment_cell_crossing_test_test.sv */
module segment_cell_crossing_test_test
   import crossing_check_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned LONG_HOLD   = 400;
   localparam int unsigned TAIL_CYCLES = 10;

   logic clock;
   logic reset;

   scct_req_if #(.COORD_BITS(COORD_BITS)) req_if ();
   scct_rsp_if                            rsp_if ();

   segment_cell_crossing_test #(
      .COORD_BITS(COORD_BITS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   hit_scoreboard sb = new();

   // idle/stall odds in percent, changed per phase
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   // nonzero asks the receiver process for a long hold-off of that many cycles
   int unsigned hold_request  = 0;
   int unsigned cycle_count   = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog: runs out only if the block hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // monitor: note accepted requests first, then check the response beat, so a
   // same-edge answer would still find its expectation
   always @(posedge clock) begin
      cell_ray_type seen;
      if (!reset) begin
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            seen.ray_start_x = req_if.ray_start_x;
            seen.ray_start_y = req_if.ray_start_y;
            seen.ray_end_x   = req_if.ray_end_x;
            seen.ray_end_y   = req_if.ray_end_y;
            seen.corner_a_x  = req_if.corner_a_x;
            seen.corner_a_y  = req_if.corner_a_y;
            seen.corner_b_x  = req_if.corner_b_x;
            seen.corner_b_y  = req_if.corner_b_y;
            seen.corner_c_x  = req_if.corner_c_x;
            seen.corner_c_y  = req_if.corner_c_y;
            seen.corner_d_x  = req_if.corner_d_x;
            seen.corner_d_y  = req_if.corner_d_y;
            sb.note_request(seen);
         end
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            sb.check_hit(rsp_if.hit);
      end
   end

   // one request beat; random idle cycles in front, then hold until accepted
   task automatic send_beat(cell_ray_type beat);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.ray_start_x <= beat.ray_start_x;
      req_if.ray_start_y <= beat.ray_start_y;
      req_if.ray_end_x   <= beat.ray_end_x;
      req_if.ray_end_y   <= beat.ray_end_y;
      req_if.corner_a_x  <= beat.corner_a_x;
      req_if.corner_a_y  <= beat.corner_a_y;
      req_if.corner_b_x  <= beat.corner_b_x;
      req_if.corner_b_y  <= beat.corner_b_y;
      req_if.corner_c_x  <= beat.corner_c_x;
      req_if.corner_c_y  <= beat.corner_c_y;
      req_if.corner_d_x  <= beat.corner_d_x;
      req_if.corner_d_y  <= beat.corner_d_y;
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   task automatic send_coords(int sx, int sy, int ex, int ey, int ax, int ay,
                              int bx, int by, int cx, int cy, int dx, int dy);
      cell_ray_type beat;
      beat = '{coord_type'(sx), coord_type'(sy), coord_type'(ex), coord_type'(ey),
               coord_type'(ax), coord_type'(ay), coord_type'(bx), coord_type'(by),
               coord_type'(cx), coord_type'(cy), coord_type'(dx), coord_type'(dy)};
      send_beat(beat);
   endtask

   // sender pause: drop valid and wait for every expected beat; the wait steps the
   // clock before it checks, so the last accepted beat is noted first
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // grid point; coarse grids keep collinear and touching cases frequent
   function automatic coord_type grid_coord(int scale);
      int v;
      v = int'($urandom_range(0, 30)) - 15;
      return coord_type'(v * scale);
   endfunction

   function automatic coord_type edge_coord();
      case ($urandom_range(0, 7))
         0:       return 16'sh8000;
         1:       return 16'sh8001;
         2:       return 16'shFFFF;
         3:       return 16'sh0000;
         4:       return 16'sh0001;
         5:       return 16'sh7FFE;
         6:       return 16'sh7FFF;
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic cell_ray_type random_beat();
      cell_ray_type b;
      int           scale;
      int unsigned  style;
      coord_type    x0, y0, x1, y1;
      case ($urandom_range(0, 2))
         0:       scale = 1;
         1:       scale = 64;
         default: scale = 2048;
      endcase
      style = $urandom_range(0, 99);
      // axis-aligned cell, as map cells come, kept by the rectangle and along-side styles
      x0 = grid_coord(scale);
      y0 = grid_coord(scale);
      x1 = grid_coord(scale);
      y1 = grid_coord(scale);
      b.corner_a_x = x0;  b.corner_a_y = y0;
      b.corner_b_x = x1;  b.corner_b_y = y0;
      b.corner_c_x = x1;  b.corner_c_y = y1;
      b.corner_d_x = x0;  b.corner_d_y = y1;
      b.ray_start_x = grid_coord(scale);
      b.ray_start_y = grid_coord(scale);
      b.ray_end_x   = grid_coord(scale);
      b.ray_end_y   = grid_coord(scale);
      if (style < 30) begin
         // rectangle cell, free ray on the same grid
      end else if (style < 55) begin
         // arbitrary quad, sometimes with a collapsed side
         b.corner_a_x = grid_coord(scale);  b.corner_a_y = grid_coord(scale);
         b.corner_c_x = grid_coord(scale);  b.corner_c_y = grid_coord(scale);
         b.corner_b_x = grid_coord(scale);  b.corner_b_y = grid_coord(scale);
         b.corner_d_x = grid_coord(scale);  b.corner_d_y = grid_coord(scale);
         if ($urandom_range(0, 9) == 0) begin
            b.corner_b_x = b.corner_a_x;
            b.corner_b_y = b.corner_a_y;
         end
      end else if (style < 70) begin
         // ray runs along the line of one side
         case ($urandom_range(0, 3))
            0:       begin b.ray_start_y = y0; b.ray_end_y = y0; end
            1:       begin b.ray_start_x = x1; b.ray_end_x = x1; end
            2:       begin b.ray_start_y = y1; b.ray_end_y = y1; end
            default: begin b.ray_start_x = x0; b.ray_end_x = x0; end
         endcase
      end else if (style < 85) begin
         b = cell_ray_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      end else begin
         b.ray_start_x = edge_coord();  b.ray_start_y = edge_coord();
         b.ray_end_x   = edge_coord();  b.ray_end_y   = edge_coord();
         b.corner_a_x  = edge_coord();  b.corner_a_y  = edge_coord();
         b.corner_b_x  = edge_coord();  b.corner_b_y  = edge_coord();
         b.corner_c_x  = edge_coord();  b.corner_c_y  = edge_coord();
         b.corner_d_x  = edge_coord();  b.corner_d_y  = edge_coord();
      end
      // point ray now and then
      if (style < 70 && $urandom_range(0, 9) == 0) begin
         b.ray_end_x = b.ray_start_x;
         b.ray_end_y = b.ray_start_y;
      end
      return b;
   endfunction

   task automatic send_random(int unsigned count);
      repeat (count) send_beat(random_beat());
   endtask

   initial begin
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.ray_start_x <= '0;
      req_if.ray_start_y <= '0;
      req_if.ray_end_x   <= '0;
      req_if.ray_end_y   <= '0;
      req_if.corner_a_x  <= '0;
      req_if.corner_a_y  <= '0;
      req_if.corner_b_x  <= '0;
      req_if.corner_b_y  <= '0;
      req_if.corner_c_x  <= '0;
      req_if.corner_c_y  <= '0;
      req_if.corner_d_x  <= '0;
      req_if.corner_d_y  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unit square a(0,0) b(256,0) c(256,256) d(0,256) unless noted
      send_coords(-512, 128, 512, 128,   0, 0, 256, 0, 256, 256, 0, 256);  // clean crossing
      send_coords(64, 64, 192, 192,      0, 0, 256, 0, 256, 256, 0, 256);  // inside, no side
      send_coords(512, 512, 1024, 700,   0, 0, 256, 0, 256, 256, 0, 256);  // far away
      send_coords(256, 256, 512, 512,    0, 0, 256, 0, 256, 256, 0, 256);  // touches corner c
      send_coords(128, 0, 128, 0,        0, 0, 256, 0, 256, 256, 0, 256);  // point ray on a-b
      send_coords(128, 128, 128, 128,    0, 0, 256, 0, 256, 256, 0, 256);  // point ray inside
      send_coords(128, -100, 128, 0,     0, 0, 256, 0, 256, 256, 0, 256);  // ends on a-b
      send_coords(-100, 0, 100, 0,       0, 0, 256, 0, 256, 256, 0, 256);  // collinear overlap
      send_coords(300, 0, 400, 0,        0, 0, 256, 0, 256, 256, 0, 256);  // collinear, apart
      send_coords(256, 0, 400, 0,        0, 0, 256, 0, 256, 256, 0, 256);  // collinear, at b
      send_coords(0, 100, 0, 500,        0, 0, 256, 0, 256, 256, 0, 256);  // overlap on a-d
      send_coords(0, -300, 0, -1,        0, 0, 256, 0, 256, 256, 0, 256);  // collinear, short
      // whole cell collapsed to one point, on and off the ray
      send_coords(0, 0, 200, 200,        100, 100, 100, 100, 100, 100, 100, 100);
      send_coords(0, 0, 200, 200,        100, 101, 100, 101, 100, 101, 100, 101);
      // full-scale extremes
      send_coords(-32768, -32768, 32767, 32767,
                  -32768, 32767, 32767, 32767, 32767, -32768, -32768, -32768);
      send_coords(-32768, 32767, 32767, -32768, 0, 0, 256, 0, 256, 256, 0, 256);
      send_coords(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                  -32768, -32768, -32768, -32768);
      send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                  32767, 32767, 32767, 32767);
      send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      // diamond cell, long vertical ray through it
      send_coords(0, -32768, 0, 32767,   0, -256, 256, 0, 0, 256, -256, 0);
      // bow-tie corner order, ray through the waist
      send_coords(-512, 128, 512, 128,   0, 0, 256, 256, 256, 0, 0, 256);
      // far ray, coordinates near the top of the range
      send_coords(32000, -32000, 32767, -32767, -32768, 32767, -32000, 32767,
                  -32000, 32000, -32768, 32000);
      wait_drained();

      // random phases
      send_idle_pct = 0;   rsp_stall_pct = 0;   send_random(300);
      send_idle_pct = 76;  rsp_stall_pct = 0;   send_random(250);
      send_idle_pct = 0;   rsp_stall_pct = 76;  send_random(250);
      send_idle_pct = 10;  rsp_stall_pct = 10;  send_random(250);

      // back-pressure: receiver holds off while the sender keeps offering,
      // pipeline fills and ready drops; then pause until all beats are back
      send_idle_pct = 0;   rsp_stall_pct = 0;
      hold_request = LONG_HOLD;
      send_random(60);
      wait_drained();

      send_idle_pct = 10;  rsp_stall_pct = 10;  send_random(20);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("hit: %0d expected beats never arrived", sb.pending());
         sb.fail_count++;
      end
      if (sb.fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
